// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the leg touchdown phase detector
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked property, muted while reset is asserted
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked property, checked during reset as well
`define ASSERT_CLKD_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_CLKD_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/ltpd_pkg.sv =====
// Shared types, constants and helpers of the leg touchdown phase detector
package ltpd_pkg;

  localparam int unsigned NUM_LEGS      = 3;
  localparam int unsigned FORCE_W       = 16;
  localparam int unsigned MAG_W         = 17;
  localparam int unsigned THRESH_W      = 15;
  localparam int unsigned TICKS_W       = 16;
  localparam int unsigned COUNT_W       = 17;
  localparam int unsigned STEP_NUM_W    = 16;
  localparam int unsigned PHASE_W       = 2;
  localparam int unsigned CFG_INDEX_W   = 3;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [TICKS_W-1:0] TIMEOUT_TICKS = 16'd3000;

  // Register reset values
  localparam logic [TICKS_W-1:0] IGNORE_TICKS_RST = 16'd500;
  localparam logic [TICKS_W-1:0] STEP_TICKS_RST   = 16'd1000;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOUCHDOWN_THRESHOLD = 3'd0,
    REG_SUPPORT_THRESHOLD   = 3'd1,
    REG_IGNORE_TICKS        = 3'd2,
    REG_STEP_TICKS          = 3'd3,
    REG_SENSING_ENABLE      = 3'd4
  } cfg_reg_t;

  // Leg phase codes
  typedef enum logic [PHASE_W-1:0] {
    PH_SWING  = 2'd0,
    PH_TRANS  = 2'd1,
    PH_STANCE = 2'd2
  } phase_t;

  // Gait state codes
  typedef enum logic [PHASE_W-1:0] {
    GAIT_SWING  = 2'd0,
    GAIT_MIXED  = 2'd1,
    GAIT_STANCE = 2'd2
  } gait_t;

  // Absolute value of a signed force sample; the most negative value maps to 32768
  function automatic logic [MAG_W-1:0] force_mag(input logic [FORCE_W-1:0] f);
    logic [MAG_W-1:0] neg;
    neg = {1'b0, ~f} + MAG_W'(1);
    return f[FORCE_W-1] ? neg : {1'b0, f};
  endfunction

endpackage

// ===== hw/rtl/ltpd_in_if.sv =====
// Input channel: one force-sample transaction per control tick or step start
interface ltpd_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [ltpd_pkg::FORCE_W-1:0] force_leg_a;
  logic signed [ltpd_pkg::FORCE_W-1:0] force_leg_b;
  logic signed [ltpd_pkg::FORCE_W-1:0] force_leg_c;

  modport source (output valid, action, force_leg_a, force_leg_b, force_leg_c,
                  input ready);
  modport sink   (input valid, action, force_leg_a, force_leg_b, force_leg_c,
                  output ready);
endinterface

// ===== hw/rtl/ltpd_out_if.sv =====
// Result channel: leg phases, gait, step status and counters
interface ltpd_out_if;
  logic                               valid;
  logic                               ready;
  logic [ltpd_pkg::PHASE_W-1:0]       phase_leg_a;
  logic [ltpd_pkg::PHASE_W-1:0]       phase_leg_b;
  logic [ltpd_pkg::PHASE_W-1:0]       phase_leg_c;
  logic [ltpd_pkg::PHASE_W-1:0]       gait_phase;
  logic                               step_done;
  logic [ltpd_pkg::NUM_LEGS-1:0]      touchdown_events;
  logic [ltpd_pkg::NUM_LEGS-1:0]      support_events;
  logic [ltpd_pkg::COUNT_W-1:0]       tick_index;
  logic [ltpd_pkg::STEP_NUM_W-1:0]    step_number;

  modport source (output valid, phase_leg_a, phase_leg_b, phase_leg_c, gait_phase,
                  step_done, touchdown_events, support_events, tick_index,
                  step_number, input ready);
  modport sink   (input valid, phase_leg_a, phase_leg_b, phase_leg_c, gait_phase,
                  step_done, touchdown_events, support_events, tick_index,
                  step_number, output ready);
endinterface

// ===== hw/rtl/leg_touchdown_phase_detector.sv =====
// Leg touchdown phase detector: per-tick leg phase, gait and step completion
//
// Usage:
//   in_chan carries one transaction per control tick (action 0) with the
//   signed vertical force of three legs, or a step start (action 1).
//   out_chan returns exactly one result transaction per input transaction,
//   in order: leg phases, gait, step_done, event masks, tick index, step number.
//   The cfg_ port writes one register per cycle while cfg_we is high; write
//   only while no transaction is in flight.
// Timing: a result is valid in the cycle after its input is accepted.
//   One transaction per cycle is sustained while out_chan.ready is high;
//   the per-leg compares, gait reduction and step compares all settle
//   between the input handshake and the result register.
// Reset (rst_n low, synchronous): tick count, step count, leg phases and gait
//   clear to zero (swing); registers take their reset values; the result
//   register empties.
// Stall: while out_chan.ready is low and a result waits, in_chan.ready drops;
//   the result register holds its contents until it is taken.
`include "assert_macros.svh"

module leg_touchdown_phase_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  ltpd_in_if.sink                           in_chan,
  ltpd_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [ltpd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [ltpd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned NL  = ltpd_pkg::NUM_LEGS;
  localparam int unsigned CW  = ltpd_pkg::COUNT_W;
  localparam int unsigned TW  = ltpd_pkg::TICKS_W;
  localparam int unsigned PW  = ltpd_pkg::PHASE_W;
  localparam int unsigned SW  = ltpd_pkg::STEP_NUM_W;
  localparam int unsigned MW  = ltpd_pkg::MAG_W;
  localparam int unsigned THW = ltpd_pkg::THRESH_W;

  // Configuration registers
  logic [THW-1:0] touchdown_thr_r;
  logic [THW-1:0] support_thr_r;
  logic [TW-1:0]  ignore_ticks_r;
  logic [TW-1:0]  step_ticks_r;
  logic           sensing_en_r;

  // Block state
  logic [CW-1:0]  tick_count_r, tick_count_nxt;
  logic [SW-1:0]  step_counter_r, step_counter_nxt;
  logic [PW-1:0]  leg_phase_r [NL];
  logic [PW-1:0]  leg_phase_nxt [NL];
  logic [PW-1:0]  gait_r, gait_nxt;

  // Result register
  logic           out_valid_r;
  logic [PW-1:0]  out_phase_r [NL];
  logic [PW-1:0]  out_gait_r;
  logic           out_done_r;
  logic [NL-1:0]  out_td_ev_r;
  logic [NL-1:0]  out_sup_ev_r;
  logic [CW-1:0]  out_tick_r;
  logic [SW-1:0]  out_step_r;

  logic           in_fire;
  logic [MW-1:0]  mag [NL];
  logic [NL-1:0]  td_ev, sup_ev;
  logic           all_stance, all_swing;
  logic           in_window;
  logic           done;
  logic [CW:0]    count_p1;
  logic [CW:0]    limit;
  logic [CW-1:0]  tick_index;

  // Accept whenever the result register is empty or being drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire       = in_chan.valid && in_chan.ready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touchdown_thr_r <= '0;
      support_thr_r   <= '0;
      ignore_ticks_r  <= ltpd_pkg::IGNORE_TICKS_RST;
      step_ticks_r    <= ltpd_pkg::STEP_TICKS_RST;
      sensing_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (ltpd_pkg::cfg_reg_t'(cfg_index))
        ltpd_pkg::REG_TOUCHDOWN_THRESHOLD: touchdown_thr_r <= cfg_data[THW-1:0];
        ltpd_pkg::REG_SUPPORT_THRESHOLD:   support_thr_r   <= cfg_data[THW-1:0];
        ltpd_pkg::REG_IGNORE_TICKS:        ignore_ticks_r  <= cfg_data[TW-1:0];
        ltpd_pkg::REG_STEP_TICKS:          step_ticks_r    <= cfg_data[TW-1:0];
        ltpd_pkg::REG_SENSING_ENABLE:      sensing_en_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Take force magnitudes
  assign mag[0] = ltpd_pkg::force_mag(in_chan.force_leg_a);
  assign mag[1] = ltpd_pkg::force_mag(in_chan.force_leg_b);
  assign mag[2] = ltpd_pkg::force_mag(in_chan.force_leg_c);

  assign in_window = tick_count_r <= {{(CW-TW){1'b0}}, ignore_ticks_r};

  // Advance leg phases and derive gait
  always_comb begin
    td_ev      = '0;
    sup_ev     = '0;
    all_stance = 1'b1;
    all_swing  = 1'b1;
    gait_nxt   = gait_r;
    for (int k = 0; k < NL; k++) begin
      leg_phase_nxt[k] = leg_phase_r[k];
    end
    if (!in_chan.action) begin
      if (in_window) begin
        for (int k = 0; k < NL; k++) begin
          leg_phase_nxt[k] = ltpd_pkg::PH_SWING;
        end
        gait_nxt = ltpd_pkg::GAIT_SWING;
      end else if (sensing_en_r) begin
        for (int k = 0; k < NL; k++) begin
          case (ltpd_pkg::phase_t'(leg_phase_r[k]))
            ltpd_pkg::PH_SWING: begin
              if (mag[k] > {{(MW-THW){1'b0}}, touchdown_thr_r}) begin
                leg_phase_nxt[k] = ltpd_pkg::PH_TRANS;
                td_ev[k]         = 1'b1;
              end
            end
            ltpd_pkg::PH_TRANS: begin
              if (mag[k] > {{(MW-THW){1'b0}}, support_thr_r}) begin
                leg_phase_nxt[k] = ltpd_pkg::PH_STANCE;
                sup_ev[k]        = 1'b1;
              end
            end
            default: ;
          endcase
          if (leg_phase_nxt[k] != ltpd_pkg::PH_STANCE) all_stance = 1'b0;
          if (leg_phase_nxt[k] != ltpd_pkg::PH_SWING)  all_swing  = 1'b0;
        end
        if (all_stance) begin
          gait_nxt = ltpd_pkg::GAIT_STANCE;
        end else if (all_swing) begin
          gait_nxt = ltpd_pkg::GAIT_SWING;
        end else begin
          gait_nxt = ltpd_pkg::GAIT_MIXED;
        end
      end
    end
  end

  // Check step completion: count >= step_ticks - 1 is count + 1 >= step_ticks
  assign count_p1 = {1'b0, tick_count_r} + (CW+1)'(1);
  assign limit    = (CW+1)'(step_ticks_r) + (CW+1)'(ltpd_pkg::TIMEOUT_TICKS);
  assign done     = !in_chan.action &&
                    (((count_p1 >= (CW+1)'(step_ticks_r)) &&
                      (gait_nxt == ltpd_pkg::GAIT_STANCE)) ||
                     (count_p1 >= limit));

  // Update counters
  always_comb begin
    tick_count_nxt   = tick_count_r;
    step_counter_nxt = step_counter_r;
    tick_index       = tick_count_r;
    if (in_chan.action) begin
      step_counter_nxt = step_counter_r + SW'(1);
      tick_count_nxt   = '0;
      tick_index       = '0;
    end else if (tick_count_r != ltpd_pkg::COUNT_MAX) begin
      tick_count_nxt = count_p1[CW-1:0];
    end
  end

  // Hold block state, advance on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r   <= '0;
      step_counter_r <= '0;
      gait_r         <= ltpd_pkg::GAIT_SWING;
      for (int k = 0; k < NL; k++) begin
        leg_phase_r[k] <= ltpd_pkg::PH_SWING;
      end
    end else if (in_fire) begin
      tick_count_r   <= tick_count_nxt;
      step_counter_r <= step_counter_nxt;
      gait_r         <= gait_nxt;
      for (int k = 0; k < NL; k++) begin
        leg_phase_r[k] <= leg_phase_nxt[k];
      end
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_gait_r   <= gait_nxt;
      out_done_r   <= done;
      out_td_ev_r  <= td_ev;
      out_sup_ev_r <= sup_ev;
      out_tick_r   <= tick_index;
      out_step_r   <= step_counter_nxt;
      for (int k = 0; k < NL; k++) begin
        out_phase_r[k] <= leg_phase_nxt[k];
      end
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.phase_leg_a      = out_phase_r[0];
  assign out_chan.phase_leg_b      = out_phase_r[1];
  assign out_chan.phase_leg_c      = out_phase_r[2];
  assign out_chan.gait_phase       = out_gait_r;
  assign out_chan.step_done        = out_done_r;
  assign out_chan.touchdown_events = out_td_ev_r;
  assign out_chan.support_events   = out_sup_ev_r;
  assign out_chan.tick_index       = out_tick_r;
  assign out_chan.step_number      = out_step_r;

  // Assertions
  `ASSERT_CLKD(a_ready_when_empty, clk, rst_n,
    !out_valid_r |-> in_chan.ready, "input not ready with empty result register")
  `ASSERT_CLKD(a_events_disjoint, clk, rst_n,
    out_valid_r |-> ((out_td_ev_r & out_sup_ev_r) == '0),
    "leg reported touchdown and support on the same tick")
  `ASSERT_CLKD(a_start_result, clk, rst_n,
    (in_fire && in_chan.action) |=> (out_tick_r == '0 && !out_done_r &&
      out_td_ev_r == '0 && out_sup_ev_r == '0),
    "step start produced a nonzero tick index or an event")
  `ASSERT_CLKD(a_timeout_bound, clk, rst_n,
    (out_valid_r && out_done_r && out_gait_r != ltpd_pkg::GAIT_STANCE) |->
      (out_tick_r >= CW'(ltpd_pkg::TIMEOUT_TICKS) - CW'(1)),
    "step done without stance before the timeout bound")
  `ASSERT_CLKD(a_count_monotonic, clk, rst_n,
    (in_fire && !in_chan.action) |=> (tick_count_r >= $past(tick_count_r)),
    "tick count went backwards on a control tick")

endmodule

// ===== tb/leg_touchdown_phase_detector_tb.sv =====
// Testbench for the leg touchdown phase detector: table-driven and random force ticks, scoreboarded
`timescale 1ns / 100ps

module leg_touchdown_phase_detector_tb;

  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_PCT       = 37;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 75;

  // One detector report, laid out like the result channel
  typedef struct packed {
    ltpd_pkg::phase_t                  leg_a;
    ltpd_pkg::phase_t                  leg_b;
    ltpd_pkg::phase_t                  leg_c;
    ltpd_pkg::gait_t                   gait;
    logic                              done;
    logic [ltpd_pkg::NUM_LEGS-1:0]     td_ev;
    logic [ltpd_pkg::NUM_LEGS-1:0]     sup_ev;
    logic [ltpd_pkg::COUNT_W-1:0]      tick;
    logic [ltpd_pkg::STEP_NUM_W-1:0]   step_num;
  } leg_report_t;

  // Directed row: quiet rows carry a typed report that is all zero but the step number
  typedef struct {
    logic                                act;
    logic signed [ltpd_pkg::FORCE_W-1:0] fa;
    logic signed [ltpd_pkg::FORCE_W-1:0] fb;
    logic signed [ltpd_pkg::FORCE_W-1:0] fc;
    bit                                  cfg_before;
    bit                                  quiet;
    logic [ltpd_pkg::STEP_NUM_W-1:0]     quiet_step;
  } directed_row_t;

  logic                             clk;
  logic                             rst_n;
  logic                             cfg_we;
  logic [ltpd_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [ltpd_pkg::CFG_DATA_W-1:0]  cfg_data;

  ltpd_in_if  in_chan_if ();
  ltpd_out_if out_chan_if ();

  leg_touchdown_phase_detector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan_if),
    .out_chan (out_chan_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Detector shadow: configuration
  logic [ltpd_pkg::THRESH_W-1:0]   td_thr;
  logic [ltpd_pkg::THRESH_W-1:0]   sup_thr;
  logic [ltpd_pkg::TICKS_W-1:0]    ign_ticks;
  logic [ltpd_pkg::TICKS_W-1:0]    step_len;
  logic                            sense_en;

  // Detector shadow: state
  logic [ltpd_pkg::COUNT_W-1:0]    tick_cnt;
  logic [ltpd_pkg::STEP_NUM_W-1:0] step_cnt;
  ltpd_pkg::phase_t                leg_ph [ltpd_pkg::NUM_LEGS];
  ltpd_pkg::gait_t                 gait_st;

  leg_report_t pending_reports [$];
  int          mismatch_count;
  int          stall_cycles;
  bit          free_run;

  directed_row_t stim_table [11] = '{
    '{1'b0, 16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b1, 16'd0},
    '{1'b1, 16'sd32767,  -16'sd32768, -16'sd1,     1'b0, 1'b1, 16'd1},
    '{1'b0, -16'sd32768, 16'sd32767,  16'sd0,      1'b0, 1'b1, 16'd1},
    '{1'b1, 16'sd0,      16'sd0,      16'sd0,      1'b1, 1'b1, 16'd2},
    '{1'b0, 16'sd32767,  -16'sd32768, 16'sd32767,  1'b0, 1'b1, 16'd2},
    '{1'b0, 16'sd32767,  -16'sd32768, 16'sd100,    1'b0, 1'b0, 16'd0},
    '{1'b0, 16'sd1000,   16'sd1001,   16'sd101,    1'b0, 1'b0, 16'd0},
    '{1'b0, -16'sd32768, 16'sd0,      -16'sd1001,  1'b0, 1'b0, 16'd0},
    '{1'b0, 16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b0, 16'd0},
    '{1'b1, 16'sd0,      16'sd0,      16'sd0,      1'b0, 1'b0, 16'd0},
    '{1'b0, -16'sd1,     -16'sd1,     -16'sd1,     1'b0, 1'b0, 16'd0}
  };

  // Clock
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Return the detector shadow to its reset state
  task automatic reset_detector_model();
    td_thr    = '0;
    sup_thr   = '0;
    ign_ticks = ltpd_pkg::IGNORE_TICKS_RST;
    step_len  = ltpd_pkg::STEP_TICKS_RST;
    sense_en  = 1'b0;
    tick_cnt  = '0;
    step_cnt  = '0;
    gait_st   = ltpd_pkg::GAIT_SWING;
    for (int k = 0; k < ltpd_pkg::NUM_LEGS; k++) leg_ph[k] = ltpd_pkg::PH_SWING;
  endtask

  // Advance the shadow detector by one transaction and return its report
  function automatic leg_report_t advance_detector(
      input logic act,
      input logic signed [ltpd_pkg::FORCE_W-1:0] fa,
      input logic signed [ltpd_pkg::FORCE_W-1:0] fb,
      input logic signed [ltpd_pkg::FORCE_W-1:0] fc);
    leg_report_t r;
    int          mag [ltpd_pkg::NUM_LEGS];
    int          c;
    int          nominal;
    int          limit;
    bit          all_st;
    bit          all_sw;
    r      = '0;
    mag[0] = int'(fa);
    mag[1] = int'(fb);
    mag[2] = int'(fc);
    for (int k = 0; k < ltpd_pkg::NUM_LEGS; k++) if (mag[k] < 0) mag[k] = -mag[k];
    if (act) begin
      // Start a step: count it, clear the tick count, leave the legs alone
      step_cnt = step_cnt + 1'b1;
      tick_cnt = '0;
    end else begin
      c      = int'(tick_cnt);
      r.tick = tick_cnt;
      if (c <= int'(ign_ticks)) begin
        // Inside the ignore window: force every leg to swing
        for (int k = 0; k < ltpd_pkg::NUM_LEGS; k++) leg_ph[k] = ltpd_pkg::PH_SWING;
        gait_st = ltpd_pkg::GAIT_SWING;
      end else if (sense_en) begin
        all_st = 1'b1;
        all_sw = 1'b1;
        for (int k = 0; k < ltpd_pkg::NUM_LEGS; k++) begin
          if (leg_ph[k] == ltpd_pkg::PH_SWING) begin
            if (mag[k] > int'(td_thr)) begin
              leg_ph[k]  = ltpd_pkg::PH_TRANS;
              r.td_ev[k] = 1'b1;
            end
          end else if (leg_ph[k] == ltpd_pkg::PH_TRANS) begin
            if (mag[k] > int'(sup_thr)) begin
              leg_ph[k]   = ltpd_pkg::PH_STANCE;
              r.sup_ev[k] = 1'b1;
            end
          end
          if (leg_ph[k] != ltpd_pkg::PH_STANCE) all_st = 1'b0;
          if (leg_ph[k] != ltpd_pkg::PH_SWING) all_sw = 1'b0;
        end
        gait_st = all_st ? ltpd_pkg::GAIT_STANCE :
                  (all_sw ? ltpd_pkg::GAIT_SWING : ltpd_pkg::GAIT_MIXED);
      end
      // Step ends on nominal length in full stance, or on timeout
      nominal = int'(step_len) - 1;
      limit   = int'(step_len) + int'(ltpd_pkg::TIMEOUT_TICKS) - 1;
      r.done  = ((c >= nominal) && (gait_st == ltpd_pkg::GAIT_STANCE)) || (c >= limit);
      if (tick_cnt != ltpd_pkg::COUNT_MAX) tick_cnt = tick_cnt + 1'b1;
    end
    r.leg_a    = leg_ph[0];
    r.leg_b    = leg_ph[1];
    r.leg_c    = leg_ph[2];
    r.gait     = gait_st;
    r.step_num = step_cnt;
    return r;
  endfunction

  // Force sample: extremes, full-range noise, or a value hugging one of the thresholds
  function automatic logic signed [ltpd_pkg::FORCE_W-1:0] pick_force();
    int mag;
    case ($urandom_range(9))
      0: return ltpd_pkg::FORCE_W'($urandom);
      1: return -16'sd32768;
      2: return 16'sd32767;
      3: return 16'sd0;
      4: return -16'sd1;
      default: begin
        mag = ($urandom_range(1) != 0) ? int'(td_thr) : int'(sup_thr);
        mag = mag + int'($urandom_range(4)) - 2;
        if (mag < 0) mag = 0;
        if (mag > 32767) mag = 32767;
        return ($urandom_range(1) != 0) ? ltpd_pkg::FORCE_W'(mag) : ltpd_pkg::FORCE_W'(-mag);
      end
    endcase
  endfunction

  // Drive one input transaction, hold it until accepted, then log the expected report
  task automatic send_item(input logic act,
                           input logic signed [ltpd_pkg::FORCE_W-1:0] fa,
                           input logic signed [ltpd_pkg::FORCE_W-1:0] fb,
                           input logic signed [ltpd_pkg::FORCE_W-1:0] fc,
                           input bit use_typed,
                           input leg_report_t typed);
    leg_report_t predicted;
    while (!free_run && $urandom_range(99) < IDLE_PCT) begin
      in_chan_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan_if.valid       <= 1'b1;
    in_chan_if.action      <= act;
    in_chan_if.force_leg_a <= fa;
    in_chan_if.force_leg_b <= fb;
    in_chan_if.force_leg_c <= fc;
    @(posedge clk);
    while (!in_chan_if.ready) @(posedge clk);
    predicted = advance_detector(act, fa, fb, fc);
    pending_reports.push_back(use_typed ? typed : predicted);
  endtask

  // Control tick with randomly picked forces
  task automatic send_tick();
    send_item(1'b0, pick_force(), pick_force(), pick_force(), 1'b0, '0);
  endtask

  // Drop valid and wait until every expected report has come back
  task automatic drain();
    in_chan_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input ltpd_pkg::cfg_reg_t idx,
                           input logic [ltpd_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all five registers and mirror them into the shadow
  task automatic program_regs(input logic [ltpd_pkg::THRESH_W-1:0] td,
                              input logic [ltpd_pkg::THRESH_W-1:0] sup,
                              input logic [ltpd_pkg::TICKS_W-1:0] ign,
                              input logic [ltpd_pkg::TICKS_W-1:0] stp,
                              input logic sen);
    write_reg(ltpd_pkg::REG_TOUCHDOWN_THRESHOLD, ltpd_pkg::CFG_DATA_W'(td));
    write_reg(ltpd_pkg::REG_SUPPORT_THRESHOLD, ltpd_pkg::CFG_DATA_W'(sup));
    write_reg(ltpd_pkg::REG_IGNORE_TICKS, ign);
    write_reg(ltpd_pkg::REG_STEP_TICKS, stp);
    write_reg(ltpd_pkg::REG_SENSING_ENABLE, ltpd_pkg::CFG_DATA_W'(sen));
    cfg_we    <= 1'b0;
    td_thr    = td;
    sup_thr   = sup;
    ign_ticks = ign;
    step_len  = stp;
    sense_en  = sen;
    @(posedge clk);
  endtask

  // Mostly well-formed steps: a start, then a run of ticks; the first run continues the last step
  task automatic run_steps(input int n_items);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if (sent != 0 && $urandom_range(4) != 0) begin
        send_item(1'b1, pick_force(), pick_force(), pick_force(), 1'b0, '0);
        sent++;
      end
      run_len = $urandom_range(60, 3);
      if (run_len > n_items - sent) run_len = n_items - sent;
      repeat (run_len) begin
        send_tick();
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Result side: random backpressure, compare each transaction with the oldest expectation
  always @(posedge clk) begin : collect_reports
    leg_report_t want;
    if (!rst_n) begin
      out_chan_if.ready <= 1'b0;
    end else begin
      if (out_chan_if.valid && out_chan_if.ready) begin
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          $error("report: unexpected transaction, tick_index %0d", out_chan_if.tick_index);
        end else begin
          want = pending_reports.pop_front();
          check_field("phase_leg_a", want.leg_a, out_chan_if.phase_leg_a);
          check_field("phase_leg_b", want.leg_b, out_chan_if.phase_leg_b);
          check_field("phase_leg_c", want.leg_c, out_chan_if.phase_leg_c);
          check_field("gait_phase", want.gait, out_chan_if.gait_phase);
          check_field("step_done", want.done, out_chan_if.step_done);
          check_field("touchdown_events", want.td_ev, out_chan_if.touchdown_events);
          check_field("support_events", want.sup_ev, out_chan_if.support_events);
          check_field("tick_index", want.tick, out_chan_if.tick_index);
          check_field("step_number", want.step_num, out_chan_if.step_number);
        end
      end
      out_chan_if.ready <= free_run || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan_if.valid && in_chan_if.ready) ||
        (out_chan_if.valid && out_chan_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("leg_touchdown_phase_detector_tb: done, errors");
      $finish;
    end
  end

  initial begin
    leg_report_t typed;
    clk                    = 1'b0;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = ltpd_pkg::REG_TOUCHDOWN_THRESHOLD;
    cfg_data               = '0;
    in_chan_if.valid       = 1'b0;
    in_chan_if.action      = 1'b0;
    in_chan_if.force_leg_a = '0;
    in_chan_if.force_leg_b = '0;
    in_chan_if.force_leg_c = '0;
    out_chan_if.ready      = 1'b0;
    mismatch_count         = 0;
    stall_cycles           = 0;
    free_run               = 1'b0;
    reset_detector_model();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: reset defaults, ignore window, each phase change, extreme forces
    foreach (stim_table[i]) begin
      if (stim_table[i].cfg_before) begin
        drain();
        program_regs(15'd100, 15'd1000, 16'd0, 16'd3, 1'b1);
      end
      typed          = '0;
      typed.step_num = stim_table[i].quiet_step;
      send_item(stim_table[i].act, stim_table[i].fa, stim_table[i].fb, stim_table[i].fc,
                stim_table[i].quiet, typed);
    end

    // Zero thresholds, ignore window down to tick 0 only, zero step length
    drain();
    program_regs(15'd0, 15'd0, 16'd0, 16'd0, 1'b1);
    run_steps(PHASE_ITEMS);

    // Top thresholds and window: ticks stay in the ignore window, so every leg is held in swing
    drain();
    program_regs(15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1'b1);
    run_steps(PHASE_ITEMS);

    drain();
    program_regs(15'($urandom_range(3000, 50)), 15'($urandom_range(20000, 50)),
                 16'($urandom_range(10)), 16'($urandom_range(40, 1)), 1'b1);
    run_steps(PHASE_ITEMS);

    // Sensing off: legs left mid-step hold their phase until a new step's ignore window sets swing
    drain();
    program_regs(15'($urandom_range(3000)), 15'($urandom_range(3000)),
                 16'($urandom_range(2)), 16'($urandom_range(40, 1)), 1'b0);
    run_steps(PHASE_ITEMS);

    // Back to back, no idling on either side
    drain();
    program_regs(15'($urandom_range(32767)), 15'($urandom_range(32767)),
                 16'($urandom_range(3)), 16'($urandom_range(8, 1)), 1'b1);
    free_run = 1'b1;
    run_steps(PHASE_ITEMS);
    free_run = 1'b0;

    drain();
    program_regs(15'($urandom_range(32767)), 15'($urandom_range(500)),
                 16'($urandom_range(5)), 16'($urandom_range(30, 1)), 1'b1);
    run_steps(PHASE_ITEMS);

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("leg_touchdown_phase_detector_tb: done, clean");
    end else begin
      $display("leg_touchdown_phase_detector_tb: done, errors");
    end
    $finish;
  end

endmodule
